### src/jsv_pkg.sv
// Shared types, codes and character helpers of the JSON stream validator.
// Depends on nothing; jsv_core, jsv_result_queue and the top level import it.
package jsv_pkg;

  localparam logic [3:0] K_NONE      = 4'd0;
  localparam logic [3:0] K_OBJ_OPEN  = 4'd1;
  localparam logic [3:0] K_OBJ_CLOSE = 4'd2;
  localparam logic [3:0] K_ARR_OPEN  = 4'd3;
  localparam logic [3:0] K_ARR_CLOSE = 4'd4;
  localparam logic [3:0] K_COMMA     = 4'd5;
  localparam logic [3:0] K_COLON     = 4'd6;
  localparam logic [3:0] K_STRING    = 4'd7;
  localparam logic [3:0] K_NUMBER    = 4'd8;
  localparam logic [3:0] K_TRUE      = 4'd9;
  localparam logic [3:0] K_FALSE     = 4'd10;
  localparam logic [3:0] K_NULL      = 4'd11;
  localparam logic [3:0] K_END       = 4'd12;

  localparam logic [4:0] E_OK          = 5'd0;
  localparam logic [4:0] E_ESC_INVALID = 5'd1;
  localparam logic [4:0] E_ESC_REQUIRED = 5'd2;
  localparam logic [4:0] E_ARRAY_NEXT  = 5'd4;
  localparam logic [4:0] E_COLON       = 5'd5;
  localparam logic [4:0] E_END         = 5'd6;
  localparam logic [4:0] E_VALUE       = 5'd7;
  localparam logic [4:0] E_MORE        = 5'd8;
  localparam logic [4:0] E_OBJECT_FIRST = 5'd9;
  localparam logic [4:0] E_OBJECT_NEXT = 5'd10;
  localparam logic [4:0] E_STRING      = 5'd11;
  localparam logic [4:0] E_INVALID     = 5'd12;
  localparam logic [4:0] E_ZERO        = 5'd13;
  localparam logic [4:0] E_HEX_FORMAT  = 5'd14;
  localparam logic [4:0] E_HIGH_ESCAPE = 5'd15;
  localparam logic [4:0] E_HIGH_SURR   = 5'd16;
  localparam logic [4:0] E_LOW_SURR    = 5'd17;
  localparam logic [4:0] E_DEPTH       = 5'd18;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_STRING  = 3'd1;
  localparam logic [2:0] M_ESC     = 3'd2;
  localparam logic [2:0] M_HEX     = 3'd3;
  localparam logic [2:0] M_NUMBER  = 3'd4;
  localparam logic [2:0] M_KEYWORD = 3'd5;

  localparam logic [2:0] N_MINUS   = 3'd0;
  localparam logic [2:0] N_ZERO    = 3'd1;
  localparam logic [2:0] N_INT     = 3'd2;
  localparam logic [2:0] N_DOT     = 3'd3;
  localparam logic [2:0] N_FRAC    = 3'd4;
  localparam logic [2:0] N_EXP     = 3'd5;
  localparam logic [2:0] N_EXPSIGN = 3'd6;
  localparam logic [2:0] N_EXPDIG  = 3'd7;

  localparam logic [2:0] G_VALUE        = 3'd0;
  localparam logic [2:0] G_ARRAY_START  = 3'd1;
  localparam logic [2:0] G_ARRAY_NEXT   = 3'd2;
  localparam logic [2:0] G_OBJECT_START = 3'd3;
  localparam logic [2:0] G_OBJECT_LABEL = 3'd4;
  localparam logic [2:0] G_OBJECT_NEXT  = 3'd5;
  localparam logic [2:0] G_OBJECT_COMMA = 3'd6;
  localparam logic [2:0] G_END          = 3'd7;

  localparam logic [39:0] WORD_TRUE  = 40'h0074727565;
  localparam logic [39:0] WORD_NULL  = 40'h006E756C6C;
  localparam logic [39:0] WORD_FALSE = 40'h66616C7365;
  localparam logic [23:0] LINE_MAX   = 24'hFFFFFF;

  localparam logic [1:0] REG_CHECK_ESCAPES = 2'd0;
  localparam logic [1:0] REG_UTF8_TARGET   = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       doc_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [4:0]  error_code;
    logic [6:0]  nest_level;
    logic [23:0] line_no;
    logic        last_result;
  } out_item_t;

  // Results of one accepted byte beat, in order, handed to the result queue.
  typedef struct packed {
    logic [1:0]      count;
    out_item_t [2:0] items;
  } res_bundle_t;

  typedef struct packed {
    logic [2:0] fill;
  } queue_status_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return (b inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"}) || b[7];
  endfunction

endpackage

### src/jsv_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
// Payload type is set by the instantiating level; no package dependency.
interface jsv_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/jsv_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module jsv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/jsv_core.sv
// Lexer, grammar checker: one byte beat per fired cycle, nesting stack in a RAM.
// Depends on jsv_pkg and jsv_ram.
module jsv_core #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  jsv_pkg::in_item_t   item,
  input  logic                check_escapes,
  input  logic                utf8_target,
  output jsv_pkg::res_bundle_t bundle
);
  import jsv_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef struct packed {
    logic [2:0]      m;
    logic [2:0]      np;
    logic [39:0]     kw;
    logic [2:0]      kwc;
    logic [15:0]     ha;
    logic [2:0]      hc;
    logic            sp;
    logic [2:0]      ctx;
    logic [DW-1:0]   depth;
    logic            top;
    logic            below;
    logic            push;
    logic            push_obj;
    logic [23:0]     ln;
    logic            hl;
    logic            chk;
    logic            utf8;
    logic [1:0]      n;
    out_item_t [2:0] res;
  } ws_t;

  logic [2:0]    mode;
  logic [2:0]    phase;
  logic [39:0]   kw_chars;
  logic [2:0]    kw_count;
  logic [15:0]   hex_acc;
  logic [2:0]    hex_count;
  logic          surr_pending;
  logic [2:0]    context_q;
  logic [DW-1:0] depth;
  logic          top_is_obj;
  logic [23:0]   line_count;
  logic          halted;

  logic          stack_rdata;
  logic [AW-1:0] stack_raddr;
  logic [DW:0]   raddr_wide;
  ws_t           w;

  function automatic void emit_f(inout ws_t s, input logic [3:0] k, input logic [4:0] e);
    if (s.n != 2'd3) begin
      s.res[s.n].token_kind  = k;
      s.res[s.n].error_code  = e;
      s.res[s.n].nest_level  = 7'(s.depth);
      s.res[s.n].line_no     = s.ln;
      s.res[s.n].last_result = 1'b0;
      s.n = s.n + 2'd1;
    end
  endfunction

  function automatic void fail_f(inout ws_t s, input logic [4:0] e);
    emit_f(s, K_NONE, e);
    s.hl = 1'b1;
    s.m  = M_IDLE;
  endfunction

  function automatic void value_done_f(inout ws_t s);
    if (s.depth == '0) begin
      s.ctx = G_END;
    end else begin
      s.ctx = s.top ? G_OBJECT_NEXT : G_ARRAY_NEXT;
    end
  endfunction

  // A pop exposes the entry below the top, which the RAM keeps ready.
  function automatic void close_f(inout ws_t s);
    if (s.depth != '0) begin
      s.depth = s.depth - DW'(1);
      s.top   = s.below;
    end
    value_done_f(s);
  endfunction

  function automatic logic [4:0] open_f(inout ws_t s, input logic [3:0] k);
    logic obj;
    obj = (k == K_OBJ_OPEN);
    if (k == K_OBJ_OPEN || k == K_ARR_OPEN) begin
      if (32'(s.depth) >= MAX_DEPTH) begin
        return E_DEPTH;
      end
      s.push     = 1'b1;
      s.push_obj = obj;
      s.depth    = s.depth + DW'(1);
      s.top      = obj;
      s.ctx      = obj ? G_OBJECT_START : G_ARRAY_START;
      return E_OK;
    end
    value_done_f(s);
    return E_OK;
  endfunction

  function automatic logic [4:0] grammar_f(inout ws_t s, input logic [3:0] k);
    logic isval;
    isval = (k == K_OBJ_OPEN) || (k == K_ARR_OPEN) || (k inside {[K_STRING:K_NULL]});
    case (s.ctx)
      G_VALUE: begin
        return isval ? open_f(s, k) : E_VALUE;
      end
      G_ARRAY_START: begin
        if (k == K_ARR_CLOSE) begin
          close_f(s);
          return E_OK;
        end
        return isval ? open_f(s, k) : E_VALUE;
      end
      G_ARRAY_NEXT: begin
        if (k == K_COMMA) begin
          s.ctx = G_VALUE;
          return E_OK;
        end
        if (k == K_ARR_CLOSE) begin
          close_f(s);
          return E_OK;
        end
        return E_ARRAY_NEXT;
      end
      G_OBJECT_START: begin
        if (k == K_STRING) begin
          s.ctx = G_OBJECT_LABEL;
          return E_OK;
        end
        if (k == K_OBJ_CLOSE) begin
          close_f(s);
          return E_OK;
        end
        return E_OBJECT_FIRST;
      end
      G_OBJECT_LABEL: begin
        if (k == K_COLON) begin
          s.ctx = G_VALUE;
          return E_OK;
        end
        return E_COLON;
      end
      G_OBJECT_NEXT: begin
        if (k == K_COMMA) begin
          s.ctx = G_OBJECT_COMMA;
          return E_OK;
        end
        if (k == K_OBJ_CLOSE) begin
          close_f(s);
          return E_OK;
        end
        return E_OBJECT_NEXT;
      end
      G_OBJECT_COMMA: begin
        if (k == K_STRING) begin
          s.ctx = G_OBJECT_LABEL;
          return E_OK;
        end
        return E_STRING;
      end
      default: begin
        return E_END;
      end
    endcase
  endfunction

  function automatic void tok_f(inout ws_t s, input logic [3:0] k);
    logic [4:0] e;
    e = grammar_f(s, k);
    if (e != E_OK) begin
      fail_f(s, e);
    end else begin
      emit_f(s, k, E_OK);
    end
  endfunction

  function automatic void finish_kw_f(inout ws_t s);
    logic [39:0] wd;
    logic [2:0]  c;
    wd    = s.kw;
    c     = s.kwc;
    s.m   = M_IDLE;
    s.kw  = '0;
    s.kwc = '0;
    if (c == 3'd4 && wd == WORD_TRUE) begin
      tok_f(s, K_TRUE);
    end else if (c == 3'd4 && wd == WORD_NULL) begin
      tok_f(s, K_NULL);
    end else if (c == 3'd5 && wd == WORD_FALSE) begin
      tok_f(s, K_FALSE);
    end else begin
      fail_f(s, E_INVALID);
    end
  endfunction

  // Returns 1 when the number keeps the byte (or the byte made it invalid).
  function automatic logic number_f(inout ws_t s, input logic [7:0] b);
    logic dig;
    logic ex;
    logic open;
    dig  = is_digit(b);
    ex   = (b == "e") || (b == "E");
    open = 1'b0;
    case (s.np)
      N_MINUS: begin
        if (b == "0") s.np = N_ZERO;
        else if (dig) s.np = N_INT;
        else fail_f(s, E_INVALID);
      end
      N_ZERO, N_INT: begin
        if (dig && s.np == N_INT) begin
        end else if (b == ".") begin
          s.np = N_DOT;
        end else if (ex) begin
          s.np = N_EXP;
        end else begin
          open = 1'b1;
        end
      end
      N_DOT: begin
        if (dig) s.np = N_FRAC;
        else fail_f(s, E_INVALID);
      end
      N_FRAC: begin
        if (dig) begin
        end else if (ex) begin
          s.np = N_EXP;
        end else begin
          open = 1'b1;
        end
      end
      N_EXP: begin
        if (b == "+" || b == "-") s.np = N_EXPSIGN;
        else if (dig) s.np = N_EXPDIG;
        else fail_f(s, E_INVALID);
      end
      N_EXPSIGN: begin
        if (dig) s.np = N_EXPDIG;
        else fail_f(s, E_INVALID);
      end
      default: begin
        if (!dig) open = 1'b1;
      end
    endcase
    if (open) begin
      if (is_alnum(b)) begin
        fail_f(s, E_INVALID);
        return 1'b1;
      end
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void hex_f(inout ws_t s, input logic [7:0] b);
    logic [3:0]  v;
    logic [15:0] ch;
    logic        big;
    logic        bad;
    big = 1'b0;
    bad = 1'b0;
    v   = '0;
    if (b inside {["0":"9"]}) v = 4'(b - "0");
    else if (b inside {["a":"f"]}) v = 4'(b - "a" + 8'd10);
    else if (b inside {["A":"F"]}) v = 4'(b - "A" + 8'd10);
    else bad = 1'b1;
    if (bad) begin
      fail_f(s, E_HEX_FORMAT);
    end else begin
      s.ha = {s.ha[11:0], v};
      s.hc = s.hc + 3'd1;
      if (s.hc == 3'd4) begin
        s.hc = '0;
        s.m  = M_STRING;
        ch   = s.ha;
        if (s.chk) begin
          if (ch inside {[16'hD800:16'hDBFF]}) begin
            if (s.sp) fail_f(s, E_HIGH_SURR);
            else s.sp = 1'b1;
          end else begin
            if (ch inside {[16'hDC00:16'hDFFF]}) begin
              if (!s.sp) bad = 1'b1;
              else begin
                s.sp = 1'b0;
                big  = 1'b1;
              end
            end else if (s.sp) begin
              bad = 1'b1;
            end
            if (bad) fail_f(s, E_LOW_SURR);
            else if (!big && ch == '0) fail_f(s, E_ZERO);
            else if (!s.utf8 && (big || ch > 16'h007F)) fail_f(s, E_HIGH_ESCAPE);
          end
        end
      end
    end
  endfunction

  function automatic void idle_f(inout ws_t s, input logic [7:0] b);
    case (b)
      " ", 8'h09, 8'h0D: begin
      end
      8'h0A: begin
        if (s.ln != LINE_MAX) s.ln = s.ln + 24'd1;
      end
      "{": tok_f(s, K_OBJ_OPEN);
      "}": tok_f(s, K_OBJ_CLOSE);
      "[": tok_f(s, K_ARR_OPEN);
      "]": tok_f(s, K_ARR_CLOSE);
      ",": tok_f(s, K_COMMA);
      ":": tok_f(s, K_COLON);
      8'h22: begin
        s.m  = M_STRING;
        s.sp = 1'b0;
      end
      "-": begin
        s.m  = M_NUMBER;
        s.np = N_MINUS;
      end
      default: begin
        if (is_digit(b)) begin
          s.m  = M_NUMBER;
          s.np = (b == "0") ? N_ZERO : N_INT;
        end else if (is_alnum(b)) begin
          s.m   = M_KEYWORD;
          s.kw  = {32'd0, b};
          s.kwc = 3'd1;
        end else begin
          fail_f(s, E_INVALID);
        end
      end
    endcase
  endfunction

  always_comb begin
    logic [7:0] b;
    logic       run;
    logic       spx;
    b          = item.data_byte;
    run        = 1'b0;
    w          = '0;
    w.m        = mode;
    w.np       = phase;
    w.kw       = kw_chars;
    w.kwc      = kw_count;
    w.ha       = hex_acc;
    w.hc       = hex_count;
    w.sp       = surr_pending;
    w.ctx      = context_q;
    w.depth    = depth;
    w.top      = top_is_obj;
    w.below    = stack_rdata;
    w.ln       = line_count;
    w.hl       = halted;
    w.chk      = check_escapes;
    w.utf8     = utf8_target;
    spx        = check_escapes && surr_pending;
    if (fire && item.byte_present && !w.hl) begin
      case (w.m)
        M_STRING: begin
          if (b == 8'h22) begin
            if (spx) fail_f(w, E_LOW_SURR);
            else begin
              w.m = M_IDLE;
              tok_f(w, K_STRING);
            end
          end else if (b < 8'd32) begin
            fail_f(w, E_ESC_REQUIRED);
          end else if (b == 8'h5C) begin
            w.m = M_ESC;
          end else if (spx) begin
            fail_f(w, E_LOW_SURR);
          end
        end
        M_ESC: begin
          if (b == "u") begin
            w.m  = M_HEX;
            w.ha = '0;
            w.hc = '0;
          end else if (spx) begin
            fail_f(w, E_LOW_SURR);
          end else if (b inside {8'h22, 8'h5C, "/", "b", "f", "n", "r", "t"}) begin
            w.m = M_STRING;
          end else begin
            fail_f(w, E_ESC_INVALID);
          end
        end
        M_HEX: hex_f(w, b);
        M_NUMBER: begin
          if (!number_f(w, b)) begin
            w.m = M_IDLE;
            tok_f(w, K_NUMBER);
            run = 1'b1;
          end
        end
        M_KEYWORD: begin
          if (is_alnum(b)) begin
            if (w.kwc >= 3'd5) fail_f(w, E_INVALID);
            else begin
              w.kw  = {w.kw[31:0], b};
              w.kwc = w.kwc + 3'd1;
            end
          end else begin
            finish_kw_f(w);
            run = 1'b1;
          end
        end
        default: begin
          w.m = M_IDLE;
          run = 1'b1;
        end
      endcase
      if (run && !w.hl) idle_f(w, b);
    end
    if (fire && item.doc_end && !w.hl) begin
      if (w.m inside {M_STRING, M_ESC, M_HEX}) begin
        fail_f(w, E_INVALID);
      end else if (w.m == M_NUMBER) begin
        w.m = M_IDLE;
        if (w.np inside {N_ZERO, N_INT, N_FRAC, N_EXPDIG}) tok_f(w, K_NUMBER);
        else fail_f(w, E_INVALID);
      end else if (w.m == M_KEYWORD) begin
        finish_kw_f(w);
      end
      if (!w.hl) begin
        if (w.ctx == G_END) emit_f(w, K_END, E_OK);
        else fail_f(w, E_MORE);
      end
    end
    bundle.count = fire ? w.n : 2'd0;
    for (int i = 0; i < 3; i++) begin
      bundle.items[i]             = w.res[i];
      bundle.items[i].last_result = (2'(i) == w.n - 2'd1);
    end
  end

  // Keep the entry under the new top addressed, so a pop finds it read out.
  always_comb begin
    logic [DW-1:0] dn;
    dn = (fire && item.doc_end) ? '0 : (fire ? w.depth : depth);
    raddr_wide  = {1'b0, dn} - (DW + 1)'(2);
    stack_raddr = raddr_wide[AW-1:0];
  end

  jsv_ram #(.WIDTH(1), .DEPTH(MAX_DEPTH)) u_stack (
    .clk   (clk),
    .we    (fire && w.push),
    .waddr (depth[AW-1:0]),
    .wdata (w.push_obj),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || (fire && item.doc_end)) begin
      mode         <= M_IDLE;
      phase        <= N_MINUS;
      kw_chars     <= '0;
      kw_count     <= '0;
      hex_acc      <= '0;
      hex_count    <= '0;
      surr_pending <= 1'b0;
      context_q    <= G_VALUE;
      depth        <= '0;
      top_is_obj   <= 1'b0;
      line_count   <= 24'd1;
      halted       <= 1'b0;
    end else if (fire) begin
      mode         <= w.m;
      phase        <= w.np;
      kw_chars     <= w.kw;
      kw_count     <= w.kwc;
      hex_acc      <= w.ha;
      hex_count    <= w.hc;
      surr_pending <= w.sp;
      context_q    <= w.ctx;
      depth        <= w.depth;
      top_is_obj   <= w.top;
      line_count   <= w.ln;
      halted       <= w.hl;
    end
  end
endmodule

### src/jsv_result_queue.sv
// Four-entry result queue: takes up to three results a cycle, emits one beat.
// Depends on jsv_pkg.
module jsv_result_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  jsv_pkg::res_bundle_t   bundle,
  input  logic                   pop,
  output jsv_pkg::out_item_t     head,
  output logic                   head_valid,
  output logic                   room,
  output jsv_pkg::queue_status_t status
);
  import jsv_pkg::*;

  out_item_t  mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign head       = mem[rd_ptr];
  assign head_valid = (fill != 3'd0);
  // Room for the worst case of three results from the next byte beat.
  assign room       = (fill <= 3'd1);
  assign status.fill = fill;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < bundle.count) begin
        mem[wr_ptr + 2'(i)] <= bundle.items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + bundle.count;
      rd_ptr <= rd_ptr + 2'(pop);
      fill   <= fill + 3'(bundle.count) - 3'(pop);
    end
  end
endmodule

### src/json_stream_validator.sv
// JSON stream validator top level: register port, lexer/grammar core, result queue.
// Throughput: one byte beat per cycle while results drain at one beat a cycle;
// a beat yielding several results stalls byte intake until at most one is queued.
// Results of an accepted byte beat are registered into the queue, then offered.
// The nesting stack RAM is read ahead at the entry under the top.
// Synchronous reset initialises control state and the registers; stack needs no clear.
module json_stream_validator #(
  parameter int MAX_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  jsv_stream_if.sink   bytes,
  jsv_stream_if.source events,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jsv_pkg::*;

  logic          check_escapes;
  logic          utf8_target;
  logic          fire;
  logic          pop;
  logic          room;
  logic [1:0]    reg_index;
  res_bundle_t   bundle;
  queue_status_t qstat;

  assign pready    = 1'b1;
  assign reg_index = {1'b0, paddr[2]};
  assign prdata    = (reg_index == REG_UTF8_TARGET) ? {31'd0, utf8_target}
                                                    : {31'd0, check_escapes};

  always_ff @(posedge clk) begin
    if (rst) begin
      check_escapes <= 1'b0;
      utf8_target   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_index == REG_CHECK_ESCAPES) check_escapes <= pwdata[0];
      else utf8_target <= pwdata[0];
    end
  end

  assign bytes.ready = room;
  assign fire        = bytes.valid && room;
  assign pop         = events.valid && events.ready;

  jsv_core #(.MAX_DEPTH(MAX_DEPTH)) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (bytes.payload),
    .check_escapes (check_escapes),
    .utf8_target   (utf8_target),
    .bundle        (bundle)
  );

  jsv_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .bundle     (bundle),
    .pop        (pop),
    .head       (events.payload),
    .head_valid (events.valid),
    .room       (room),
    .status     (qstat)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) qstat.fill <= 3'd4)
    else $error("result queue overfilled");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> qstat.fill == $past(qstat.fill) + 3'($past(bundle.count)) - 3'($past(pop)))
    else $error("result queue fill does not follow pushes and pops");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |-> bundle.count == 2'd0)
    else $error("results produced without an accepted byte beat");
endmodule
